>>> design/snnltc_pkg.sv
// ----------------------------------------------------------------------------
// snnltc_pkg: shared constants, types and helpers
// Sizes, field widths, register indexes and window arithmetic helpers for
// the symmetric nearest neighbour texture count block.
// ----------------------------------------------------------------------------
`default_nettype none

package snnltc_pkg;

    localparam int MAX_HALF    = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SAT_COUNT   = 255;

    localparam int RING_ROWS   = 2 * MAX_HALF + 1;
    localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int RING_W      = $clog2(RING_ROWS);
    localparam int HALF_W      = $clog2(MAX_HALF + 1);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
    localparam int EDGE_W      = ((HGT_W > WID_W) ? HGT_W : WID_W) + 1;
    localparam int LIN_W       = ROW_W + COL_W + 1;

    localparam int PIX_W       = 8;
    localparam int CNT_W       = 8;
    localparam int LIMIT_W     = 8;
    localparam int HCFG_W      = 2;
    localparam int WCFG_W      = 11;
    localparam int TCFG_W      = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ABS_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [LIMIT_W-1:0] abs_limit;
        logic [HALF_W-1:0]  half_w;
        logic [HALF_W-1:0]  half_h;
        logic [WID_W-1:0]   width;
        logic [HGT_W-1:0]   height;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_mem_req;

    function automatic logic [HALF_W-1:0] clamp_half(logic [HCFG_W-1:0] v);
        if (int'(v) > MAX_HALF) begin
            clamp_half = HALF_W'(MAX_HALF);
        end else begin
            clamp_half = HALF_W'(v);
        end
    endfunction

    function automatic logic [WID_W-1:0] clamp_width(logic [WCFG_W-1:0] v);
        if (v == '0) begin
            clamp_width = WID_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            clamp_width = WID_W'(MAX_WIDTH);
        end else begin
            clamp_width = WID_W'(v);
        end
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(logic [TCFG_W-1:0] v);
        if (v == '0) begin
            clamp_height = HGT_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            clamp_height = HGT_W'(MAX_HEIGHT);
        end else begin
            clamp_height = HGT_W'(v);
        end
    endfunction

    // half size limited by the distance to both frame edges
    function automatic logic [HALF_W-1:0] edge_half(logic [HALF_W-1:0] h,
                                                    logic [EDGE_W-1:0] pos,
                                                    logic [EDGE_W-1:0] size);
        logic [EDGE_W-1:0] rem;
        logic [EDGE_W-1:0] r;
        r = EDGE_W'(h);
        rem = '0;
        if (pos + EDGE_W'(1) >= size) begin
            edge_half = '0;
        end else begin
            rem = size - pos - EDGE_W'(1);
            if (pos < r) begin
                r = pos;
            end
            if (rem < r) begin
                r = rem;
            end
            edge_half = HALF_W'(r);
        end
    endfunction

    function automatic logic [RING_W-1:0] ring_add(logic [RING_W-1:0] ring,
                                                   logic [HALF_W-1:0] d);
        logic [RING_W:0] s;
        s = {1'b0, ring} + (RING_W + 1)'(d);
        if (s >= (RING_W + 1)'(RING_ROWS)) begin
            s = s - (RING_W + 1)'(RING_ROWS);
        end
        ring_add = s[RING_W-1:0];
    endfunction

    function automatic logic [RING_W-1:0] ring_sub(logic [RING_W-1:0] ring,
                                                   logic [HALF_W-1:0] d);
        logic [RING_W:0] s;
        if ({1'b0, ring} >= (RING_W + 1)'(d)) begin
            s = {1'b0, ring} - (RING_W + 1)'(d);
        end else begin
            s = {1'b0, ring} + (RING_W + 1)'(RING_ROWS) - (RING_W + 1)'(d);
        end
        ring_sub = s[RING_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(logic [RING_W-1:0] ring,
                                                   logic [COL_W-1:0] col);
        mem_addr = ADDR_W'(int'(ring) * MAX_WIDTH + int'(col));
    endfunction

endpackage

`default_nettype wire

>>> design/snnltc_in_if.sv
// ----------------------------------------------------------------------------
// snnltc_in_if: input item channel
// Valid/ready channel carrying a command and a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface snnltc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [snnltc_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output command, output pixel, input ready);
    modport sink   (input valid, input command, input pixel, output ready);
endinterface

`default_nettype wire

>>> design/snnltc_out_if.sv
// ----------------------------------------------------------------------------
// snnltc_out_if: result item channel
// Valid/ready channel carrying the pair count and the frame end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface snnltc_out_if;
    logic                        valid;
    logic                        ready;
    logic [snnltc_pkg::CNT_W-1:0] count;
    logic                        frame_last;

    modport source (output valid, output count, output frame_last, input ready);
    modport sink   (input valid, input count, input frame_last, output ready);
endinterface

`default_nettype wire

>>> design/snnltc_store.sv
// ----------------------------------------------------------------------------
// snnltc_store: line buffer memory
// Ring of line buffers, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module snnltc_store (
    input  wire logic                         i_clk,
    input  wire snnltc_pkg::t_mem_req         i_req,
    output logic [snnltc_pkg::PIX_W-1:0]      o_rd_a,
    output logic [snnltc_pkg::PIX_W-1:0]      o_rd_b
);

    logic [snnltc_pkg::PIX_W-1:0] r_mem [snnltc_pkg::STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rd_a <= r_mem[i_req.raddr_a];
        o_rd_b <= r_mem[i_req.raddr_b];
    end

endmodule

`default_nettype wire

>>> design/snnltc_pair_cmp.sv
// ----------------------------------------------------------------------------
// snnltc_pair_cmp: mirrored pair compare unit
// Tests whether either pixel of a mirrored pair lies within the limit of
// the centre pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module snnltc_pair_cmp (
    input  wire logic [snnltc_pkg::LIMIT_W-1:0] i_limit,
    input  wire logic [snnltc_pkg::PIX_W-1:0]   i_ctr,
    input  wire logic [snnltc_pkg::PIX_W-1:0]   i_pix_a,
    input  wire logic [snnltc_pkg::PIX_W-1:0]   i_pix_b,
    output logic                                o_hit
);

    logic [snnltc_pkg::PIX_W-1:0] diff_a;
    logic [snnltc_pkg::PIX_W-1:0] diff_b;

    always_comb begin
        diff_a = (i_pix_a >= i_ctr) ? (i_pix_a - i_ctr) : (i_ctr - i_pix_a);
        diff_b = (i_pix_b >= i_ctr) ? (i_pix_b - i_ctr) : (i_ctr - i_pix_b);
        o_hit  = (diff_a <= i_limit) || (diff_b <= i_limit);
    end

endmodule

`default_nettype wire

>>> design/snnltc_seq.sv
// ----------------------------------------------------------------------------
// snnltc_seq: pixel and window sequencer
// Tracks input and output raster positions, decides when a result is due
// and walks the mirrored pairs of the window through the compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module snnltc_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire snnltc_pkg::t_cfg            i_cfg,
    snnltc_in_if.sink                        i_in,
    snnltc_out_if.source                     o_out,
    output snnltc_pkg::t_mem_req             o_mem,
    input  wire logic [snnltc_pkg::PIX_W-1:0] i_rd_a,
    output logic [snnltc_pkg::PIX_W-1:0]     o_ctr,
    input  wire logic                        i_hit
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOUT = 3'd1;
    localparam logic [2:0] ST_LAG  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_CTR  = 3'd4;
    localparam logic [2:0] ST_WALK = 3'd5;
    localparam logic [2:0] ST_LAST = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam int EW = snnltc_pkg::EDGE_W;
    localparam int LW = snnltc_pkg::LIN_W;
    localparam int HW = snnltc_pkg::HALF_W;
    localparam int CW = snnltc_pkg::COL_W;
    localparam int RW = snnltc_pkg::ROW_W;
    localparam int GW = snnltc_pkg::RING_W;

    logic [2:0]                     r_state, n_state;
    logic [CW-1:0]                  r_in_col, n_in_col;
    logic [RW-1:0]                  r_in_row, n_in_row;
    logic [GW-1:0]                  r_in_ring, n_in_ring;
    logic [CW-1:0]                  r_out_col, n_out_col;
    logic [RW-1:0]                  r_out_row, n_out_row;
    logic [GW-1:0]                  r_out_ring, n_out_ring;
    logic                           r_draining, n_draining;
    logic                           r_pv, n_pv;
    logic                           r_ctr_pend, n_ctr_pend;

    logic [LW-1:0]                  r_lin_in, n_lin_in;
    logic [LW-1:0]                  r_lin_out, n_lin_out;
    logic [LW-1:0]                  r_prod, n_prod;
    logic [HW-1:0]                  r_h, n_h;
    logic [HW-1:0]                  r_dy, n_dy;
    logic signed [HW:0]             r_dx, n_dx;
    logic [snnltc_pkg::PIX_W-1:0]   r_ctr, n_ctr;
    logic [snnltc_pkg::CNT_W-1:0]   r_tally, n_tally;
    logic                           r_last, n_last;

    logic                           in_fire;
    logic [RW-1:0]                  mul_a;
    logic [CW-1:0]                  mul_b;
    logic [LW-1:0]                  mul_res;
    logic                           lag_hit;
    logic [HW-1:0]                  h_col;
    logic [HW-1:0]                  h_row;
    logic                           walk_end;
    logic signed [CW+1:0]           sum_a;
    logic signed [CW+1:0]           sum_b;
    logic [snnltc_pkg::ADDR_W-1:0]  addr_ctr;
    logic [snnltc_pkg::ADDR_W-1:0]  addr_a;
    logic [snnltc_pkg::ADDR_W-1:0]  addr_b;
    logic                           in_row_end;
    logic                           in_col_end;
    logic                           out_row_end;
    logic                           out_col_end;

    assign in_fire      = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == ST_IDLE);
    assign o_out.valid  = (r_state == ST_OUT);
    assign o_out.count  = r_tally;
    assign o_out.frame_last = r_last;
    assign o_ctr        = r_ctr;

    // shared position multiplier: row * width + column
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                mul_a = r_in_row;
                mul_b = r_in_col;
            end
            ST_LOUT: begin
                mul_a = r_out_row;
                mul_b = r_out_col;
            end
            default: begin
                mul_a = RW'(i_cfg.half_h);
                mul_b = CW'(i_cfg.half_w);
            end
        endcase
        mul_res = LW'(mul_a) * LW'(i_cfg.width) + LW'(mul_b);
    end

    assign lag_hit = ({1'b0, r_lin_in} >= ({1'b0, r_lin_out} + {1'b0, r_prod}));

    assign h_col = snnltc_pkg::edge_half(i_cfg.half_w, EW'(r_out_col), EW'(i_cfg.width));
    assign h_row = snnltc_pkg::edge_half(i_cfg.half_h, EW'(r_out_row), EW'(i_cfg.height));

    assign in_col_end  = (EW'(r_in_col) + EW'(1) >= EW'(i_cfg.width));
    assign in_row_end  = (EW'(r_in_row) + EW'(1) >= EW'(i_cfg.height));
    assign out_col_end = (EW'(r_out_col) + EW'(1) >= EW'(i_cfg.width));
    assign out_row_end = (EW'(r_out_row) + EW'(1) >= EW'(i_cfg.height));

    assign walk_end = (r_dy == '0) && (r_dx == '0);

    // mirrored pair addresses
    always_comb begin
        sum_a    = $signed({2'b00, r_out_col}) + (CW + 2)'(r_dx);
        sum_b    = $signed({2'b00, r_out_col}) - (CW + 2)'(r_dx);
        addr_ctr = snnltc_pkg::mem_addr(r_out_ring, r_out_col);
        addr_a   = snnltc_pkg::mem_addr(snnltc_pkg::ring_sub(r_out_ring, r_dy),
                                        sum_a[CW-1:0]);
        addr_b   = snnltc_pkg::mem_addr(snnltc_pkg::ring_add(r_out_ring, r_dy),
                                        sum_b[CW-1:0]);
    end

    always_comb begin
        o_mem.we      = 1'b0;
        o_mem.waddr   = snnltc_pkg::mem_addr(r_in_ring, r_in_col);
        o_mem.wdata   = i_in.pixel;
        o_mem.raddr_a = (r_state == ST_CTR) ? addr_ctr : addr_a;
        o_mem.raddr_b = addr_b;

        n_state    = r_state;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_ring  = r_in_ring;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_ring = r_out_ring;
        n_draining = r_draining;
        n_pv       = 1'b0;
        n_ctr_pend = 1'b0;
        n_lin_in   = r_lin_in;
        n_lin_out  = r_lin_out;
        n_prod     = r_prod;
        n_h        = r_h;
        n_dy       = r_dy;
        n_dx       = r_dx;
        n_ctr      = r_ctr;
        n_tally    = r_tally;
        n_last     = r_last;

        if (r_pv && i_hit && (r_tally != snnltc_pkg::CNT_W'(snnltc_pkg::SAT_COUNT))) begin
            n_tally = r_tally + snnltc_pkg::CNT_W'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (r_draining) begin
                        n_state = ST_CTR;
                    end else if (i_in.command == snnltc_pkg::CMD_PIXEL) begin
                        o_mem.we = 1'b1;
                        n_lin_in = mul_res;
                        if (in_col_end) begin
                            n_in_col = '0;
                            if (in_row_end) begin
                                n_in_row   = '0;
                                n_in_ring  = '0;
                                n_draining = 1'b1;
                            end else begin
                                n_in_row  = r_in_row + RW'(1);
                                n_in_ring = (r_in_ring == GW'(snnltc_pkg::RING_ROWS - 1)) ?
                                            '0 : r_in_ring + GW'(1);
                            end
                        end else begin
                            n_in_col = r_in_col + CW'(1);
                        end
                        n_state = ST_LOUT;
                    end
                end
            end
            ST_LOUT: begin
                n_lin_out = mul_res;
                n_state   = ST_LAG;
            end
            ST_LAG: begin
                n_prod  = mul_res;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = lag_hit ? ST_CTR : ST_IDLE;
            end
            ST_CTR: begin
                n_h        = h_col;
                n_dy       = h_row;
                n_dx       = -$signed({1'b0, h_col});
                n_tally    = '0;
                n_ctr_pend = 1'b1;
                n_state    = ST_WALK;
            end
            ST_WALK: begin
                if (r_ctr_pend) begin
                    n_ctr = i_rd_a;
                end
                if (walk_end) begin
                    n_state = ST_LAST;
                end else begin
                    n_pv = 1'b1;
                    if (r_dx == $signed({1'b0, r_h})) begin
                        n_dx = -$signed({1'b0, r_h});
                        n_dy = r_dy - HW'(1);
                    end else begin
                        n_dx = r_dx + (HW + 1)'(1);
                    end
                end
            end
            ST_LAST: begin
                n_last = out_col_end && out_row_end;
                if (out_col_end) begin
                    n_out_col = '0;
                    if (out_row_end) begin
                        n_out_row  = '0;
                        n_out_ring = '0;
                        n_draining = 1'b0;
                    end else begin
                        n_out_row  = r_out_row + RW'(1);
                        n_out_ring = (r_out_ring == GW'(snnltc_pkg::RING_ROWS - 1)) ?
                                     '0 : r_out_ring + GW'(1);
                    end
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_ring  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_ring <= '0;
            r_draining <= 1'b0;
            r_pv       <= 1'b0;
            r_ctr_pend <= 1'b0;
            r_tally    <= '0;
        end else begin
            r_state    <= n_state;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_ring  <= n_in_ring;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_ring <= n_out_ring;
            r_draining <= n_draining;
            r_pv       <= n_pv;
            r_ctr_pend <= n_ctr_pend;
            r_tally    <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin_in  <= n_lin_in;
        r_lin_out <= n_lin_out;
        r_prod    <= n_prod;
        r_h       <= n_h;
        r_dy      <= n_dy;
        r_dx      <= n_dx;
        r_ctr     <= n_ctr;
        r_last    <= n_last;
    end

endmodule

`default_nettype wire

>>> design/snn_lit_texture_count.sv
// ----------------------------------------------------------------------------
// snn_lit_texture_count: symmetric nearest neighbour texture count
// Streams a raster frame through line buffers and counts, for each pixel,
// the mirrored window pairs with a member close to the centre pixel.
// ----------------------------------------------------------------------------
// One item is taken at a time. A pixel that releases no result passes the
// accept step and the LOUT, LAG and CMP states: the shared position
// multiplier forms the input and output positions and the window lag, and
// CMP compares the input position against the output position plus the lag.
// A pixel or drain tick that releases a result walks CTR, WALK and LAST; WALK
// takes the P = v*(2h+1) + h mirrored pairs of the edge-limited window (at
// most 24 with the full 7x7 window), one pair per cycle through the dual read
// port of the line buffer memory and the pair compare unit; OUT then holds
// until the result is taken. A drain tick before the last pixel of the frame
// is taken and gives no result. The line buffers are not cleared after reset;
// every location is written before the window reaches it.
// ----------------------------------------------------------------------------
`default_nettype none

module snn_lit_texture_count (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [snnltc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [snnltc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    snnltc_in_if.sink                                 i_in,
    snnltc_out_if.source                              o_out
);

    snnltc_pkg::t_cfg             r_cfg;
    snnltc_pkg::t_mem_req         mem_req;
    logic [snnltc_pkg::PIX_W-1:0] rd_a;
    logic [snnltc_pkg::PIX_W-1:0] rd_b;
    logic [snnltc_pkg::PIX_W-1:0] ctr;
    logic                         hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abs_limit <= '0;
            r_cfg.half_w    <= snnltc_pkg::clamp_half(snnltc_pkg::HCFG_W'(1));
            r_cfg.half_h    <= snnltc_pkg::clamp_half(snnltc_pkg::HCFG_W'(1));
            r_cfg.width     <= snnltc_pkg::clamp_width(snnltc_pkg::WCFG_W'(512));
            r_cfg.height    <= snnltc_pkg::clamp_height(snnltc_pkg::TCFG_W'(512));
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                snnltc_pkg::REG_ABS_LIMIT: begin
                    r_cfg.abs_limit <= i_cfg_data[snnltc_pkg::LIMIT_W-1:0];
                end
                snnltc_pkg::REG_HALF_WIDTH: begin
                    r_cfg.half_w <= snnltc_pkg::clamp_half(
                                        i_cfg_data[snnltc_pkg::HCFG_W-1:0]);
                end
                snnltc_pkg::REG_HALF_HEIGHT: begin
                    r_cfg.half_h <= snnltc_pkg::clamp_half(
                                        i_cfg_data[snnltc_pkg::HCFG_W-1:0]);
                end
                snnltc_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.width <= snnltc_pkg::clamp_width(
                                       i_cfg_data[snnltc_pkg::WCFG_W-1:0]);
                end
                snnltc_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.height <= snnltc_pkg::clamp_height(
                                        i_cfg_data[snnltc_pkg::TCFG_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    snnltc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_mem   (mem_req),
        .i_rd_a  (rd_a),
        .o_ctr   (ctr),
        .i_hit   (hit)
    );

    snnltc_store u_store (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    snnltc_pair_cmp u_cmp (
        .i_limit (r_cfg.abs_limit),
        .i_ctr   (ctr),
        .i_pix_a (rd_a),
        .i_pix_b (rd_b),
        .o_hit   (hit)
    );

endmodule

`default_nettype wire

>>> design/snnltc_checker.sv
// ----------------------------------------------------------------------------
// snnltc_checker: port level checks
// Watches the item channels of the texture count block over time.
// ----------------------------------------------------------------------------
`default_nettype none

module snnltc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [snnltc_pkg::CNT_W-1:0] i_out_count,
    input wire logic                         i_out_frame_last
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_count) && $stable(i_out_frame_last))
        else $error("stalled result changed");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result waits");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("second result without a new item");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result one cycle after accept");

endmodule

bind snn_lit_texture_count snnltc_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_count      (o_out.count),
    .i_out_frame_last (o_out.frame_last)
);

`default_nettype wire

>>> tb/snn_lit_texture_count_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snn_lit_texture_count_tb: self-checking bench for the texture count block
// Streams frames of pixels and drain ticks into the block under several
// window setups and handshake idle mixes, predicts every pair count with a
// bit-accurate line buffer model and checks each result item in order.
// ----------------------------------------------------------------------------
module snn_lit_texture_count_tb;

    localparam int CNT_W       = snnltc_pkg::CNT_W;
    localparam int LIMIT_W     = snnltc_pkg::LIMIT_W;
    localparam int HCFG_W      = snnltc_pkg::HCFG_W;
    localparam int WCFG_W      = snnltc_pkg::WCFG_W;
    localparam int TCFG_W      = snnltc_pkg::TCFG_W;
    localparam int PIX_W       = snnltc_pkg::PIX_W;
    localparam int STORE_DEPTH = snnltc_pkg::STORE_DEPTH;
    localparam int RING_ROWS   = snnltc_pkg::RING_ROWS;
    localparam int MAX_WIDTH   = snnltc_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = snnltc_pkg::MAX_HEIGHT;
    localparam int MAX_HALF    = snnltc_pkg::MAX_HALF;
    localparam int SAT_COUNT   = snnltc_pkg::SAT_COUNT;
    localparam int CFG_IDX_W   = snnltc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = snnltc_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_ABS_LIMIT    = snnltc_pkg::REG_ABS_LIMIT;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = snnltc_pkg::REG_HALF_WIDTH;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = snnltc_pkg::REG_HALF_HEIGHT;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = snnltc_pkg::REG_IMAGE_WIDTH;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = snnltc_pkg::REG_IMAGE_HEIGHT;
    localparam logic CMD_PIXEL = snnltc_pkg::CMD_PIXEL;
    localparam logic CMD_DRAIN = snnltc_pkg::CMD_DRAIN;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 170;

    class texture_count_checker;
        typedef struct {
            bit [CNT_W-1:0] count;
            bit             frame_last;
        } t_pair_count;

        bit [LIMIT_W-1:0] abs_limit   = '0;
        bit [HCFG_W-1:0]  half_w      = 2'd1;
        bit [HCFG_W-1:0]  half_h      = 2'd1;
        bit [WCFG_W-1:0]  img_w       = 11'd512;
        bit [TCFG_W-1:0]  img_h       = 13'd512;
        bit [PIX_W-1:0]   line_mem [STORE_DEPTH];
        int               in_col, in_row, out_col, out_row;
        bit               draining;
        t_pair_count      pending_counts [$];
        int               errors, items_taken, pixel_count, drain_items, results_checked;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ABS_LIMIT:    abs_limit = val[LIMIT_W-1:0];
                REG_HALF_WIDTH:   half_w = val[HCFG_W-1:0];
                REG_HALF_HEIGHT:  half_h = val[HCFG_W-1:0];
                REG_IMAGE_WIDTH:  img_w = val[WCFG_W-1:0];
                REG_IMAGE_HEIGHT: img_h = val[TCFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int eff_w();
            if (img_w == 0) return 1;
            return (int'(img_w) > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
        endfunction

        function int eff_h();
            if (img_h == 0) return 1;
            return (int'(img_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_h);
        endfunction

        function int half_of(bit [HCFG_W-1:0] h);
            return (int'(h) > MAX_HALF) ? MAX_HALF : int'(h);
        endfunction

        function int edge_lim(int h, int pos, int size);
            if (pos < h) h = pos;
            if (size - 1 - pos < h) h = size - 1 - pos;
            return (h < 0) ? 0 : h;
        endfunction

        function int pix_at(int r, int c);
            if (r < 0 || c < 0 || c >= MAX_WIDTH) return 0;
            return int'(line_mem[(r % RING_ROWS) * MAX_WIDTH + c]);
        endfunction

        function bit near_centre(int p, int c);
            int d;
            d = (p > c) ? p - c : c - p;
            return d <= int'(abs_limit);
        endfunction

        function int window_count(int y, int x);
            int h, v, ctr, dy, dx, n;
            h = edge_lim(half_of(half_w), x, eff_w());
            v = edge_lim(half_of(half_h), y, eff_h());
            ctr = pix_at(y, x);
            n = 0;
            for (dy = 1; dy <= v; dy++)
                for (dx = -h; dx <= h; dx++)
                    if (near_centre(pix_at(y - dy, x + dx), ctr) ||
                        near_centre(pix_at(y + dy, x - dx), ctr))
                        n++;
            for (dx = -h; dx <= -1; dx++)
                if (near_centre(pix_at(y, x + dx), ctr) ||
                    near_centre(pix_at(y, x - dx), ctr))
                    n++;
            return (n > SAT_COUNT) ? SAT_COUNT : n;
        endfunction

        function void release_count();
            t_pair_count r;
            r.count = CNT_W'(window_count(out_row, out_col));
            r.frame_last = (out_col + 1 >= eff_w()) && (out_row + 1 >= eff_h());
            pending_counts.push_back(r);
            if (out_col + 1 >= eff_w()) begin
                out_col = 0;
                out_row = (out_row + 1 >= eff_h()) ? 0 : out_row + 1;
            end else begin
                out_col++;
            end
            if (r.frame_last) draining = 1'b0;
        endfunction

        function void absorb_item(logic cmd, logic [PIX_W-1:0] pix);
            int w, hg, lin_in, lin_out, lag;
            w = eff_w();
            hg = eff_h();
            items_taken++;
            if (cmd != CMD_PIXEL || draining) begin
                drain_items++;
                if (draining) release_count();
                return;
            end
            pixel_count++;
            if (in_col < MAX_WIDTH) line_mem[(in_row % RING_ROWS) * MAX_WIDTH + in_col] = pix;
            lin_in = in_row * w + in_col;
            if (in_col + 1 >= w) begin
                in_col = 0;
                if (in_row + 1 >= hg) begin
                    in_row = 0;
                    draining = 1'b1;
                end else begin
                    in_row++;
                end
            end else begin
                in_col++;
            end
            lin_out = out_row * w + out_col;
            lag = half_of(half_h) * w + half_of(half_w);
            if (lin_in >= lin_out + lag) release_count();
        endfunction

        function bit at_frame_start();
            return in_col == 0 && in_row == 0 && !draining;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_count(logic [CNT_W-1:0] cnt, logic flast);
            t_pair_count e;
            results_checked++;
            if (pending_counts.size() == 0) begin
                report($sformatf("result %0d (count %0d) with none expected",
                                 results_checked, cnt));
            end else begin
                e = pending_counts.pop_front();
                if (cnt !== e.count)
                    report($sformatf("result %0d count %0d, expected %0d",
                                     results_checked, cnt, e.count));
                if (flast !== e.frame_last)
                    report($sformatf("result %0d frame_last %b, expected %b",
                                     results_checked, flast, e.frame_last));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    bit                    hold_req;
    int                    frames_done;

    snnltc_in_if  in_if ();
    snnltc_out_if out_if ();

    texture_count_checker sb = new();

    snn_lit_texture_count uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(val);
        @(posedge i_clk);
        sb.set_reg(idx, CFG_DATA_W'(val));
    endtask

    task automatic load_window_setup(input int lim, input int hw, input int hh,
                                     input int w, input int h);
        write_reg(REG_ABS_LIMIT, lim);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_HALF_HEIGHT, hh);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.command = cmd;
        in_if.pixel = pix;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.absorb_item(cmd, pix);
    endtask

    // let the last item finish inside the block before touching registers
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one whole frame with random content, mid-frame drain ticks as noise
    task automatic run_frame(input int noise_pct);
        int start, base, spread, p;
        start = sb.pixel_count;
        base = $urandom_range(0, 255);
        spread = $urandom_range(0, 40);
        do begin
            if (sb.draining) begin
                if ($urandom_range(0, 99) < 20)
                    send_item(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
                else
                    send_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 99) < noise_pct) begin
                send_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    p = $urandom_range(0, 255);
                end else begin
                    p = base + $urandom_range(0, 2 * spread) - spread;
                    p = (p < 0) ? 0 : (p > 255) ? 255 : p;
                end
                send_item(CMD_PIXEL, PIX_W'(p));
            end
        end while (sb.pixel_count == start || !sb.at_frame_start());
        frames_done++;
        wait_idle();
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
        int target, w, h, lim;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = sb.items_taken + budget;
        while (sb.items_taken < target) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            h = $urandom_range(1, 8);
            case ($urandom_range(0, 4))
                0: lim = 0;
                1: lim = 255;
                default: lim = $urandom_range(0, 60);
            endcase
            load_window_setup(lim, $urandom_range(0, 3), $urandom_range(0, 3), w, h);
            run_frame(10);
        end
    endtask

    // output side: random stalls, plus one long hold on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            out_if.ready = (i_rst_n === 1'b1) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_count(out_if.count, out_if.frame_last);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                cfg_we === 1'b1 || i_rst_n !== 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ABS_LIMIT;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.command = CMD_PIXEL;
        in_if.pixel = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        frames_done = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // window larger than a 3x2 frame, pixel extremes, drain in every state
        load_window_setup(255, 3, 3, 3, 2);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_DRAIN, 8'hFF);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h80);
        while (!sb.at_frame_start()) send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'h00);
        wait_idle();

        // zero sizes clamp to a single pixel, with zero lag and then with full half sizes
        load_window_setup(0, 0, 0, 0, 0);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h00);
        wait_idle();
        load_window_setup(0, 3, 3, 0, 0);
        send_item(CMD_PIXEL, 8'h07);
        send_item(CMD_DRAIN, 8'h00);
        wait_idle();

        run_phase(0, 0, PHASE_ITEMS);

        // output held off while the input keeps offering
        load_window_setup(20, 2, 2, 12, 6);
        hold_req = 1'b1;
        run_frame(5);

        run_phase(59, 0, PHASE_ITEMS);
        run_phase(0, 59, PHASE_ITEMS);
        run_phase(28, 28, PHASE_ITEMS);

        wait_idle();
        if (sb.pending_counts.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.pending_counts.size()));

        $display("covered %0d items (%0d pixels, %0d drain or discarded)",
                 sb.items_taken, sb.pixel_count, sb.drain_items);
        $display("and %0d results over %0d frames", sb.results_checked, frames_done);
        $display("half sizes 0 to 3, widths 1 to 64 and zero clamps, four idle mixes, one hold");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
